@@ sv/tsc_pkg.sv @@
`timescale 1ns / 1ps

package tsc_pkg;

   // field and accumulator widths
   localparam int RAW_W   = 11;
   localparam int COORD_W = 12;
   localparam int SUM_W   = 15;
   localparam int CNT_W   = 4;
   localparam int THR_W   = 8;
   localparam int PROD_W  = RAW_W + COORD_W;

   // burst of ten samples, counted 0..9
   localparam logic [CNT_W-1:0] BURST_LAST = CNT_W'(10 - 1);
   localparam logic [RAW_W-1:0] RAW_MAX    = '1;

   // register file
   localparam int ADDR_W    = 5;
   localparam int REG_IDX_W = 3;
   localparam int DATA_W    = 32;

   localparam logic [REG_IDX_W-1:0] REG_CALIBRATING    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RAW_LEFT       = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RAW_RIGHT      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_RAW_TOP        = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_RAW_BOTTOM     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_MOVE_THRESHOLD = 3'd7;

   localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST   = 12'd800;
   localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST  = 12'd480;
   localparam logic [THR_W-1:0]   MOVE_THRESHOLD_RST = 8'd8;

   // command handed from the front to the back through the queue
   typedef struct packed {
      logic             is_release;
      logic [RAW_W-1:0] avg_x;
      logic [RAW_W-1:0] avg_y;
   } tsc_cmd_type;

   // configuration seen by the back
   typedef struct packed {
      logic               calibrating;
      logic [RAW_W-1:0]   raw_left;
      logic [RAW_W-1:0]   raw_right;
      logic [RAW_W-1:0]   raw_top;
      logic [RAW_W-1:0]   raw_bottom;
      logic [COORD_W-1:0] screen_width;
      logic [COORD_W-1:0] screen_height;
      logic [THR_W-1:0]   move_threshold;
   } tsc_cfg_type;

endpackage

@@ sv/tsc_if.sv @@
`timescale 1ns / 1ps

// pen sample channel
interface tsc_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] x_hi;
   logic [7:0] x_lo;
   logic [7:0] y_hi;
   logic [7:0] y_lo;

   modport source (output valid, op, x_hi, x_lo, y_hi, y_lo, input ready);
   modport sink   (input valid, op, x_hi, x_lo, y_hi, y_lo, output ready);
endinterface

// reported point channel
interface tsc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tsc_pkg::COORD_W-1:0] pos_x;
   logic [tsc_pkg::COORD_W-1:0] pos_y;
   logic                        pen_down;
   logic                        calibration_point;

   modport source (output valid, pos_x, pos_y, pen_down, calibration_point, input ready);
   modport sink   (input valid, pos_x, pos_y, pen_down, calibration_point, output ready);
endinterface

@@ sv/touch_sample_conditioner.sv @@
// Touch sample conditioner: takes pen transactions (a converter sample pair or a pen
// release), averages each burst of ten samples with the lowest and highest reading
// of each axis dropped, scales the average between the raw calibration bounds to the
// screen span and posts a pen-down point only when it moved more than move_threshold
// on either axis; a release posts the last point as pen-up. The front accepts one
// transaction per cycle while the command queue (QUEUE_DEPTH entries) has room; only
// a release or the tenth sample of a burst enters the queue. When idle, the back posts
// a release as soon as its output register is free; outside calibration it scales a
// completed burst with the shared 23-step serial divider that runs once per axis, and
// an axis whose scaling is trivial skips the divider; while calibrating a burst only
// sets the current point. Registers sit at byte address 4*index; writes take effect
// at the access phase, reads return the value.
`timescale 1ns / 1ps

module touch_sample_conditioner #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   tsc_req_if.sink                       req_bus,
   tsc_rsp_if.source                     rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tsc_pkg::ADDR_W-1:0]    paddr,
   input  logic [tsc_pkg::DATA_W-1:0]    pwdata,
   output logic [tsc_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   localparam int RW = tsc_pkg::RAW_W;
   localparam int CW = tsc_pkg::COORD_W;
   localparam int TW = tsc_pkg::THR_W;
   localparam int DW = tsc_pkg::DATA_W;

   logic          calibrating_ff, calibrating_in;
   logic [RW-1:0] raw_left_ff, raw_left_in, raw_right_ff, raw_right_in;
   logic [RW-1:0] raw_top_ff, raw_top_in, raw_bottom_ff, raw_bottom_in;
   logic [CW-1:0] screen_width_ff, screen_width_in, screen_height_ff, screen_height_in;
   logic [TW-1:0] move_threshold_ff, move_threshold_in;

   logic                                reg_write;
   logic [tsc_pkg::REG_IDX_W-1:0]       reg_idx;
   tsc_pkg::tsc_cfg_type                cfg;
   logic                                cmd_push, cmd_pop, cmd_full, cmd_empty;
   tsc_pkg::tsc_cmd_type                cmd_data, cmd_head;

   // register access
   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite;
   assign reg_idx   = paddr[tsc_pkg::ADDR_W-1:2];

   always_comb begin
      calibrating_in    = calibrating_ff;
      raw_left_in       = raw_left_ff;
      raw_right_in      = raw_right_ff;
      raw_top_in        = raw_top_ff;
      raw_bottom_in     = raw_bottom_ff;
      screen_width_in   = screen_width_ff;
      screen_height_in  = screen_height_ff;
      move_threshold_in = move_threshold_ff;
      if (reg_write) begin
         case (reg_idx)
            tsc_pkg::REG_CALIBRATING:    calibrating_in    = pwdata[0];
            tsc_pkg::REG_RAW_LEFT:       raw_left_in       = pwdata[RW-1:0];
            tsc_pkg::REG_RAW_RIGHT:      raw_right_in      = pwdata[RW-1:0];
            tsc_pkg::REG_RAW_TOP:        raw_top_in        = pwdata[RW-1:0];
            tsc_pkg::REG_RAW_BOTTOM:     raw_bottom_in     = pwdata[RW-1:0];
            tsc_pkg::REG_SCREEN_WIDTH:   screen_width_in   = pwdata[CW-1:0];
            tsc_pkg::REG_SCREEN_HEIGHT:  screen_height_in  = pwdata[CW-1:0];
            tsc_pkg::REG_MOVE_THRESHOLD: move_threshold_in = pwdata[TW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calibrating_ff    <= 1'b0;
         raw_left_ff       <= '0;
         raw_right_ff      <= '0;
         raw_top_ff        <= '0;
         raw_bottom_ff     <= '0;
         screen_width_ff   <= tsc_pkg::SCREEN_WIDTH_RST;
         screen_height_ff  <= tsc_pkg::SCREEN_HEIGHT_RST;
         move_threshold_ff <= tsc_pkg::MOVE_THRESHOLD_RST;
      end else begin
         calibrating_ff    <= calibrating_in;
         raw_left_ff       <= raw_left_in;
         raw_right_ff      <= raw_right_in;
         raw_top_ff        <= raw_top_in;
         raw_bottom_ff     <= raw_bottom_in;
         screen_width_ff   <= screen_width_in;
         screen_height_ff  <= screen_height_in;
         move_threshold_ff <= move_threshold_in;
      end
   end

   // register readback
   always_comb begin
      case (reg_idx)
         tsc_pkg::REG_CALIBRATING:    prdata = DW'(calibrating_ff);
         tsc_pkg::REG_RAW_LEFT:       prdata = DW'(raw_left_ff);
         tsc_pkg::REG_RAW_RIGHT:      prdata = DW'(raw_right_ff);
         tsc_pkg::REG_RAW_TOP:        prdata = DW'(raw_top_ff);
         tsc_pkg::REG_RAW_BOTTOM:     prdata = DW'(raw_bottom_ff);
         tsc_pkg::REG_SCREEN_WIDTH:   prdata = DW'(screen_width_ff);
         tsc_pkg::REG_SCREEN_HEIGHT:  prdata = DW'(screen_height_ff);
         tsc_pkg::REG_MOVE_THRESHOLD: prdata = DW'(move_threshold_ff);
         default:                     prdata = '0;
      endcase
   end

   always_comb begin
      cfg.calibrating    = calibrating_ff;
      cfg.raw_left       = raw_left_ff;
      cfg.raw_right      = raw_right_ff;
      cfg.raw_top        = raw_top_ff;
      cfg.raw_bottom     = raw_bottom_ff;
      cfg.screen_width   = screen_width_ff;
      cfg.screen_height  = screen_height_ff;
      cfg.move_threshold = move_threshold_ff;
   end

   tsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data)
   );

   tsc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .full      (cmd_full),
      .empty     (cmd_empty)
   );

   tsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

@@ sv/tsc_front.sv @@
`timescale 1ns / 1ps

module tsc_front (
   input  logic                 clock,
   input  logic                 reset,
   tsc_req_if.sink              req_bus,
   input  logic                 cmd_full,
   output logic                 cmd_push,
   output tsc_pkg::tsc_cmd_type cmd_data
);

   logic [tsc_pkg::CNT_W-1:0] count_ff, count_in;
   logic [tsc_pkg::SUM_W-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [tsc_pkg::RAW_W-1:0] low_x_ff, low_x_in, high_x_ff, high_x_in;
   logic [tsc_pkg::RAW_W-1:0] low_y_ff, low_y_in, high_y_ff, high_y_in;

   logic                      accept;
   logic [tsc_pkg::RAW_W-1:0] raw_x, raw_y;
   logic [tsc_pkg::SUM_W-1:0] next_sum_x, next_sum_y, trim_x, trim_y;
   logic [tsc_pkg::RAW_W-1:0] next_low_x, next_high_x, next_low_y, next_high_y;

   // take a transaction whenever the queue has room
   assign req_bus.ready = !cmd_full;
   assign accept        = req_bus.valid && req_bus.ready;

   // 11-bit readings from the converter bytes
   assign raw_x = {req_bus.x_hi[6:0], req_bus.x_lo[7:4]};
   assign raw_y = {req_bus.y_hi[6:0], req_bus.y_lo[7:4]};

   // running burst totals including this sample
   always_comb begin
      next_sum_x  = sum_x_ff + tsc_pkg::SUM_W'(raw_x);
      next_sum_y  = sum_y_ff + tsc_pkg::SUM_W'(raw_y);
      next_low_x  = (raw_x < low_x_ff)  ? raw_x : low_x_ff;
      next_high_x = (raw_x > high_x_ff) ? raw_x : high_x_ff;
      next_low_y  = (raw_y < low_y_ff)  ? raw_y : low_y_ff;
      next_high_y = (raw_y > high_y_ff) ? raw_y : high_y_ff;
      trim_x = next_sum_x - tsc_pkg::SUM_W'(next_low_x) - tsc_pkg::SUM_W'(next_high_x);
      trim_y = next_sum_y - tsc_pkg::SUM_W'(next_low_y) - tsc_pkg::SUM_W'(next_high_y);
   end

   // classify: release or closing sample goes to the queue
   always_comb begin
      count_in  = count_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      low_x_in  = low_x_ff;
      high_x_in = high_x_ff;
      low_y_in  = low_y_ff;
      high_y_in = high_y_ff;
      cmd_push  = 1'b0;
      cmd_data.is_release = req_bus.op;
      cmd_data.avg_x      = trim_x[tsc_pkg::RAW_W+2:3];
      cmd_data.avg_y      = trim_y[tsc_pkg::RAW_W+2:3];
      if (accept) begin
         if (req_bus.op || count_ff == tsc_pkg::BURST_LAST) begin
            cmd_push  = 1'b1;
            count_in  = '0;
            sum_x_in  = '0;
            sum_y_in  = '0;
            low_x_in  = tsc_pkg::RAW_MAX;
            high_x_in = '0;
            low_y_in  = tsc_pkg::RAW_MAX;
            high_y_in = '0;
         end else begin
            count_in  = count_ff + 1'b1;
            sum_x_in  = next_sum_x;
            sum_y_in  = next_sum_y;
            low_x_in  = next_low_x;
            high_x_in = next_high_x;
            low_y_in  = next_low_y;
            high_y_in = next_high_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         low_x_ff  <= tsc_pkg::RAW_MAX;
         high_x_ff <= '0;
         low_y_ff  <= tsc_pkg::RAW_MAX;
         high_y_ff <= '0;
      end else begin
         count_ff  <= count_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         low_x_ff  <= low_x_in;
         high_x_ff <= high_x_in;
         low_y_ff  <= low_y_in;
         high_y_ff <= high_y_in;
      end
   end

endmodule

@@ sv/tsc_fifo.sv @@
`timescale 1ns / 1ps

module tsc_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tsc_pkg::tsc_cmd_type push_data,
   input  logic                 pop,
   output tsc_pkg::tsc_cmd_type head,
   output logic                 full,
   output logic                 empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tsc_pkg::tsc_cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("command pushed into a full queue");

endmodule

@@ sv/tsc_div.sv @@
`timescale 1ns / 1ps

module tsc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tsc_pkg::PROD_W-1:0] dividend,
   input  logic [tsc_pkg::RAW_W-1:0]  divisor,
   output logic                       done,
   output logic [tsc_pkg::PROD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(tsc_pkg::PROD_W + 1);

   logic [STEP_W-1:0]          steps_ff, steps_in;
   logic                       done_ff, done_in;
   logic [tsc_pkg::PROD_W-1:0] quo_ff, quo_in;
   logic [tsc_pkg::RAW_W-1:0]  rem_ff, rem_in;
   logic [tsc_pkg::RAW_W-1:0]  div_ff, div_in;
   logic [tsc_pkg::RAW_W:0]    trial;
   logic                       fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[tsc_pkg::PROD_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      steps_in = steps_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      done_in  = 1'b0;
      if (start) begin
         steps_in = STEP_W'(tsc_pkg::PROD_W);
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (steps_ff != '0) begin
         steps_in = steps_ff - 1'b1;
         quo_in   = {quo_ff[tsc_pkg::PROD_W-2:0], fits};
         rem_in   = fits ? tsc_pkg::RAW_W'(trial - {1'b0, div_ff})
                         : trial[tsc_pkg::RAW_W-1:0];
         done_in  = (steps_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         steps_ff <= steps_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

@@ sv/tsc_back.sv @@
`timescale 1ns / 1ps

module tsc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tsc_pkg::tsc_cfg_type cfg,
   input  tsc_pkg::tsc_cmd_type cmd_head,
   input  logic                 cmd_empty,
   output logic                 cmd_pop,
   tsc_rsp_if.source            rsp_bus
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREP   = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DSTART = 3'd3;
   localparam logic [2:0] S_DWAIT  = 3'd4;
   localparam logic [2:0] S_POST   = 3'd5;

   localparam int RW = tsc_pkg::RAW_W;
   localparam int CW = tsc_pkg::COORD_W;
   localparam int PW = tsc_pkg::PROD_W;

   logic [2:0]    state_ff, state_in;
   logic          axis_ff, axis_in;
   logic [RW-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [RW-1:0] num_ff, num_in, den_ff, den_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [CW-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [CW-1:0] current_x_ff, current_x_in, current_y_ff, current_y_in;
   logic [CW-1:0] posted_x_ff, posted_x_in, posted_y_ff, posted_y_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_pos_x_ff, rsp_pos_x_in, rsp_pos_y_ff, rsp_pos_y_in;
   logic          rsp_pen_down_ff, rsp_pen_down_in;
   logic          rsp_cal_ff, rsp_cal_in;

   logic          out_free, rsp_load;
   logic          div_start, div_done;
   logic [PW-1:0] div_quo;
   logic [RW-1:0] sel_v, sel_lo, sel_hi;
   logic [CW-1:0] sel_span;
   logic          trivial;
   logic [CW-1:0] trivial_val;
   logic [RW-1:0] calc_num, calc_den;
   logic [CW-1:0] clamped;
   logic          res_we;
   logic [CW-1:0] res_val;
   logic [CW-1:0] diff_x, diff_y;
   logic          moved;

   tsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // operands of the axis in work
   always_comb begin
      sel_v    = axis_ff ? ay_ff : ax_ff;
      sel_lo   = axis_ff ? cfg.raw_top : cfg.raw_left;
      sel_hi   = axis_ff ? cfg.raw_bottom : cfg.raw_right;
      sel_span = axis_ff ? cfg.screen_height : cfg.screen_width;
   end

   // equal bounds pass through; at or beyond the near bound gives zero
   always_comb begin
      trivial     = 1'b0;
      trivial_val = '0;
      calc_num    = sel_v - sel_lo;
      calc_den    = sel_hi - sel_lo;
      if (sel_hi == sel_lo) begin
         trivial     = 1'b1;
         trivial_val = {1'b0, sel_v};
      end else if (sel_hi > sel_lo) begin
         trivial = (sel_v <= sel_lo);
      end else begin
         trivial  = (sel_v >= sel_lo);
         calc_num = sel_lo - sel_v;
         calc_den = sel_lo - sel_hi;
      end
   end

   // quotient clamped to the span
   assign clamped = (div_quo > PW'(sel_span)) ? sel_span : div_quo[CW-1:0];

   // motion test against the last posted point
   always_comb begin
      diff_x = (res_x_ff > posted_x_ff) ? res_x_ff - posted_x_ff : posted_x_ff - res_x_ff;
      diff_y = (res_y_ff > posted_y_ff) ? res_y_ff - posted_y_ff : posted_y_ff - res_y_ff;
      moved  = (diff_x > CW'(cfg.move_threshold)) || (diff_y > CW'(cfg.move_threshold));
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      axis_in         = axis_ff;
      ax_in           = ax_ff;
      ay_in           = ay_ff;
      num_in          = num_ff;
      den_in          = den_ff;
      prod_in         = prod_ff;
      current_x_in    = current_x_ff;
      current_y_in    = current_y_ff;
      posted_x_in     = posted_x_ff;
      posted_y_in     = posted_y_ff;
      rsp_pos_x_in    = rsp_pos_x_ff;
      rsp_pos_y_in    = rsp_pos_y_ff;
      rsp_pen_down_in = rsp_pen_down_ff;
      rsp_cal_in      = rsp_cal_ff;
      cmd_pop         = 1'b0;
      div_start       = 1'b0;
      rsp_load        = 1'b0;
      res_we          = 1'b0;
      res_val         = trivial_val;
      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               if (cmd_head.is_release) begin
                  if (out_free) begin
                     rsp_load        = 1'b1;
                     rsp_pos_x_in    = current_x_ff;
                     rsp_pos_y_in    = current_y_ff;
                     rsp_pen_down_in = 1'b0;
                     rsp_cal_in      = cfg.calibrating;
                     posted_x_in     = '0;
                     posted_y_in     = '0;
                     cmd_pop         = 1'b1;
                  end
               end else if (cfg.calibrating) begin
                  current_x_in = {1'b0, cmd_head.avg_x};
                  current_y_in = {1'b0, cmd_head.avg_y};
                  cmd_pop      = 1'b1;
               end else begin
                  ax_in    = cmd_head.avg_x;
                  ay_in    = cmd_head.avg_y;
                  axis_in  = 1'b0;
                  cmd_pop  = 1'b1;
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            if (trivial) begin
               res_we = 1'b1;
               if (axis_ff) begin
                  state_in = S_POST;
               end else begin
                  axis_in = 1'b1;
               end
            end else begin
               num_in   = calc_num;
               den_in   = calc_den;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PW'(num_ff) * PW'(sel_span);
            state_in = S_DSTART;
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               res_we  = 1'b1;
               res_val = clamped;
               if (axis_ff) begin
                  state_in = S_POST;
               end else begin
                  axis_in  = 1'b1;
                  state_in = S_PREP;
               end
            end
         end
         S_POST: begin
            if (!moved || out_free) begin
               current_x_in = res_x_ff;
               current_y_in = res_y_ff;
               if (moved) begin
                  rsp_load        = 1'b1;
                  rsp_pos_x_in    = res_x_ff;
                  rsp_pos_y_in    = res_y_ff;
                  rsp_pen_down_in = 1'b1;
                  rsp_cal_in      = 1'b0;
                  posted_x_in     = res_x_ff;
                  posted_y_in     = res_y_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      res_x_in     = (res_we && !axis_ff) ? res_val : res_x_ff;
      res_y_in     = (res_we && axis_ff)  ? res_val : res_y_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         current_x_ff <= '0;
         current_y_ff <= '0;
         posted_x_ff  <= '0;
         posted_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         current_x_ff <= current_x_in;
         current_y_ff <= current_y_in;
         posted_x_ff  <= posted_x_in;
         posted_y_ff  <= posted_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ax_ff           <= ax_in;
      ay_ff           <= ay_in;
      num_ff          <= num_in;
      den_ff          <= den_in;
      prod_ff         <= prod_in;
      res_x_ff        <= res_x_in;
      res_y_ff        <= res_y_in;
      rsp_pos_x_ff    <= rsp_pos_x_in;
      rsp_pos_y_ff    <= rsp_pos_y_in;
      rsp_pen_down_ff <= rsp_pen_down_in;
      rsp_cal_ff      <= rsp_cal_in;
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.pos_x             = rsp_pos_x_ff;
   assign rsp_bus.pos_y             = rsp_pos_y_ff;
   assign rsp_bus.pen_down          = rsp_pen_down_ff;
   assign rsp_bus.calibration_point = rsp_cal_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("queue popped while empty");

   a_down_not_cal: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_pen_down_in) |-> !cfg.calibrating)
      else $error("pen-down point posted while calibrating");

   a_post_tracks: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_pen_down_in) |=>
         (posted_x_ff == current_x_ff && posted_y_ff == current_y_ff))
      else $error("posted point differs from current after a down post");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DWAIT))
      else $error("divider finished outside its wait state");

endmodule
